// ----- sv/b32w_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b32w_pkg
// Shared widths, types and the symbol alphabet of the wide character
// base32 encoder.
// ---------------------------------------------------------------------------
package b32w_pkg;

   localparam int UNIT_W    = 16;                    // code unit width
   localparam int SYM_W     = 7;                     // ASCII symbol width
   localparam int GROUP_W   = 5;                     // bits per symbol
   localparam int LEAD_W    = 4;                     // most leftover bits
   localparam int WIN_W     = UNIT_W + LEAD_W;       // leftover plus unit
   localparam int PHASE_W   = 3;
   localparam int CNT_W     = 3;
   localparam logic [PHASE_W-1:0] PHASE_MAX = 3'd4;
   localparam logic [CNT_W-1:0]   CNT_SHORT = 3'd3;
   localparam logic [CNT_W-1:0]   CNT_LONG  = 3'd4;

   localparam logic [SYM_W-1:0] SYMBOL_TABLE [32] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
      7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
      7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59
   };

   // One unit of work: bits left aligned, number of symbols to emit.
   typedef struct packed {
      logic [WIN_W-1:0] window;
      logic [CNT_W-1:0] count;
      logic             final_unit;
   } job_type;

endpackage
`default_nettype wire

// ----- sv/b32w_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b32w channel interfaces
// Valid/ready channels for code units in and symbols out.
// ---------------------------------------------------------------------------
interface b32w_req_if import b32w_pkg::*;;
   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;
   logic              final_unit;

   modport source (output valid, output code_unit, output final_unit, input ready);
   modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface b32w_rsp_if import b32w_pkg::*;;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol_char;
   logic             run_end;
   logic             message_end;

   modport source (output valid, output symbol_char, output run_end, output message_end,
                   input ready);
   modport sink   (input valid, input symbol_char, input run_end, input message_end,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/b32w_pack.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b32w_pack
// Holds the leftover bits between code units and lines up each new unit
// behind them as a left-aligned window with its symbol count.
// ---------------------------------------------------------------------------
module b32w_pack import b32w_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [UNIT_W-1:0] code_unit,
   input  wire logic              final_unit,
   output job_type                job
);

   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [LEAD_W-1:0]        lead_ff, lead_in;
   logic [PHASE_W-1:0]       phase_use;
   logic [WIN_W+LEAD_W-1:0]  spread;
   logic [PHASE_W-1:0]       phase_next;
   logic [LEAD_W-1:0]        lead_mask;

   // guard: a phase beyond the top counts as empty
   assign phase_use = (phase_ff > PHASE_MAX) ? '0 : phase_ff;
   assign spread    = {lead_ff, code_unit, LEAD_W'(0)} << (PHASE_MAX - phase_use);

   always_comb begin
      case (phase_use)
         3'd0:    begin phase_next = 3'd1; lead_mask = 4'b0001; end
         3'd1:    begin phase_next = 3'd2; lead_mask = 4'b0011; end
         3'd2:    begin phase_next = 3'd3; lead_mask = 4'b0111; end
         3'd3:    begin phase_next = 3'd4; lead_mask = 4'b1111; end
         default: begin phase_next = 3'd0; lead_mask = 4'b0000; end
      endcase
   end

   always_comb begin
      job.window     = spread[WIN_W+LEAD_W-1:LEAD_W];
      job.final_unit = final_unit;
      if (phase_use == PHASE_MAX || final_unit) begin
         job.count = CNT_LONG;
      end else begin
         job.count = CNT_SHORT;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      lead_in  = lead_ff;
      if (take) begin
         if (final_unit) begin
            phase_in = '0;
            lead_in  = '0;
         end else begin
            phase_in = phase_next;
            lead_in  = code_unit[LEAD_W-1:0] & lead_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         lead_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         lead_ff  <= lead_in;
      end
   end

`ifndef SYNTHESIS
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_MAX)
      else $error("b32w_pack: phase out of range");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      take && final_unit |=> phase_ff == '0 && lead_ff == '0)
      else $error("b32w_pack: leftover kept after final unit");

   a_lead_fits: assert property (@(posedge clock) disable iff (reset)
      (lead_ff >> phase_ff) == '0)
      else $error("b32w_pack: leftover bits wider than phase");
`endif

endmodule
`default_nettype wire

// ----- sv/b32w_emit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b32w_emit
// Work slot that peels five bits a cycle off the window unless the output
// is stalled, and the output register that presents each symbol beat.
// ---------------------------------------------------------------------------
module b32w_emit import b32w_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      job_valid,
   output logic           job_ready,
   input  wire job_type   job,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output logic [SYM_W-1:0] rsp_symbol_char,
   output logic           rsp_run_end,
   output logic           rsp_message_end
);

   logic [WIN_W-1:0] win_ff, win_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             fin_ff, fin_in;
   logic             slot_ff, slot_in;
   logic             out_valid_ff, out_valid_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic             run_ff, run_in;
   logic             msg_ff, msg_in;
   logic             out_load, step, last, take;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign step      = slot_ff && out_load;
   assign last      = (left_ff == CNT_W'(1));
   assign job_ready = !slot_ff || (step && last);
   assign take      = job_valid && job_ready;

   always_comb begin
      win_in  = win_ff;
      left_in = left_ff;
      fin_in  = fin_ff;
      slot_in = slot_ff;
      if (take) begin
         win_in  = job.window;
         left_in = job.count;
         fin_in  = job.final_unit;
         slot_in = 1'b1;
      end else if (step) begin
         win_in  = win_ff << GROUP_W;
         left_in = left_ff - CNT_W'(1);
         if (last) begin
            slot_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      sym_in       = sym_ff;
      run_in       = run_ff;
      msg_in       = msg_ff;
      if (out_load) begin
         out_valid_in = step;
      end
      if (step) begin
         sym_in = SYMBOL_TABLE[win_ff[WIN_W-1 -: GROUP_W]];
         run_in = last;
         msg_in = last && fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
      win_ff <= win_in;
      fin_ff <= fin_in;
      sym_ff <= sym_in;
      run_ff <= run_in;
      msg_ff <= msg_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol_char = sym_ff;
   assign rsp_run_end     = run_ff;
   assign rsp_message_end = msg_ff;

`ifndef SYNTHESIS
   a_msg_ends_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && msg_ff |-> run_ff)
      else $error("b32w_emit: message end without run end");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff |-> left_ff != '0 && left_ff <= CNT_LONG)
      else $error("b32w_emit: bad symbol count in slot");

   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      step && last |=> out_valid_ff && run_ff)
      else $error("b32w_emit: last symbol not flagged");
`endif

endmodule
`default_nettype wire

// ----- sv/base32_wide_char_encoder.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// base32_wide_char_encoder
// Packs 16-bit code units into 5-bit groups and emits one ASCII symbol each.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one code unit per beat plus final_unit, set on the last
//   unit of a message. rsp_if carries one symbol per beat from the alphabet
//   0-9, A-H, J, K, M, N, P-Y; run_end marks the last symbol of a unit and
//   message_end the last symbol of the message.
//   Path: the edge that takes a unit loads the work slot, and the slot then
//   registers each symbol into the output register that drives rsp_if.
//   Throughput: one symbol per cycle while rsp_if.ready stays high. A unit
//   gives three symbols, or four when four bits are left over from before it
//   or when a final unit flushes its leftover bits as an extra zero-padded
//   symbol; b32w_pack sets this count and the work slot in b32w_emit the
//   rate; it takes the next unit in the cycle it issues its last symbol.
//   Stall: when rsp_if.ready is low the output register holds, the slot
//   stops and req_if.ready drops once the slot is busy.
//   Reset: synchronous, active high; clears the leftover bits and empties
//   the slot and output register. After a final unit the leftover state
//   also returns to empty, so the next beat starts a new message.
// ---------------------------------------------------------------------------
module base32_wide_char_encoder import b32w_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   b32w_req_if.sink    req_if,
   b32w_rsp_if.source  rsp_if
);

   job_type job;
   logic    take;

   assign take = req_if.valid && req_if.ready;

   b32w_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .code_unit  (req_if.code_unit),
      .final_unit (req_if.final_unit),
      .job        (job)
   );

   b32w_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (req_if.valid),
      .job_ready       (req_if.ready),
      .job             (job),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_symbol_char (rsp_if.symbol_char),
      .rsp_run_end     (rsp_if.run_end),
      .rsp_message_end (rsp_if.message_end)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the wide character base32 encoder. Code units go
// in as whole messages; a bit-level packer in the bench predicts every
// symbol and its run_end and message_end flags, and a monitor compares each
// symbol beat with the oldest prediction. Both channels idle at random. One
// phase holds the symbol side off long enough to back up the unit side.
// ---------------------------------------------------------------------------
module tb import b32w_pkg::*;;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_UNITS = 290;

   typedef struct {
      logic [SYM_W-1:0] symbol;
      logic             run_end;
      logic             message_end;
   } symbol_beat_type;

   logic clock;
   logic reset;

   b32w_req_if req_ch ();
   b32w_rsp_if rsp_ch ();

   base32_wide_char_encoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   symbol_beat_type pending_symbols[$];
   logic [2:0]   left_count;      // count of leftover bits carried between units
   logic [4:0]   left_bits;       // leftover bits, top aligned in a group
   bit           failed;
   bit           send_idle;
   bit           recv_idle;
   int           rsp_hold_cycles;
   int           cycles;

   always #1 clock = ~clock;

   // Map a 5-bit group onto 0-9, A-H, J, K, M, N, P-Y.
   function automatic logic [SYM_W-1:0] group_symbol(input int grp);
      if (grp < 10) return SYM_W'(8'h30 + grp);
      if (grp < 18) return SYM_W'(8'h41 + grp - 10);
      if (grp < 20) return SYM_W'(8'h41 + grp - 9);
      if (grp < 22) return SYM_W'(8'h41 + grp - 8);
      return SYM_W'(8'h41 + grp - 7);
   endfunction

   function automatic void push_symbol(input int grp, input bit run_last, input bit msg_last);
      symbol_beat_type b;
      b.symbol      = group_symbol(grp & 31);
      b.run_end     = run_last;
      b.message_end = msg_last;
      pending_symbols.insert(pending_symbols.size(), b);
   endfunction

   function automatic void encode_unit(input logic [UNIT_W-1:0] code, input logic fin);
      int  lead_n;
      int  window;
      int  nbits;
      int  ngroups;
      int  rem;
      bit  last;
      lead_n = left_count;
      if (lead_n > 4) lead_n = 0;
      window  = ((int'(left_bits) >> (5 - lead_n)) << 16) | int'(code);
      nbits   = 16 + lead_n;
      ngroups = nbits / 5;
      rem     = nbits % 5;
      for (int i = 0; i < ngroups; i++) begin
         last = (i == ngroups - 1) && (!fin || rem == 0);
         push_symbol(window >> (nbits - 5 * (i + 1)), last, last && fin);
      end
      if (rem != 0) begin
         left_bits  = 5'((window & ((1 << rem) - 1)) << (5 - rem));
         left_count = 3'(rem);
      end else begin
         left_bits  = '0;
         left_count = '0;
      end
      if (fin) begin
         if (rem != 0) push_symbol(int'(left_bits), 1'b1, 1'b1);
         left_bits  = '0;
         left_count = '0;
      end
   endfunction

   // Offer one unit; valid stays high after the beat so back-to-back units
   // need no toggle on it.
   task automatic send_unit(input logic [UNIT_W-1:0] code, input logic fin);
      int gap;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.code_unit  <= code;
      req_ch.final_unit <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      encode_unit(code, fin);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
   endtask

   function automatic logic [UNIT_W-1:0] draw_unit();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return UNIT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_single_units();
      send_unit(16'h0000, 1'b1);
      send_unit(16'hFFFF, 1'b1);
      send_unit(16'h8000, 1'b1);
      send_unit(16'h0001, 1'b1);
      wait_drained();
   endtask

   // Messages of 2 to 5 units end at leftover phases 1 to 4; five units leave
   // nothing over, so no flush symbol follows.
   task automatic test_phase_walk();
      for (int len = 2; len <= 5; len++) begin
         for (int k = 0; k < len; k++)
            send_unit((k % 2) ? 16'hAAAA : 16'h5555 ^ 16'(len), k == len - 1);
      end
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'h0000, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int k = 0; k < 10; k++)
         send_unit(draw_unit(), k == 9);
      wait_drained();
      send_idle = 1'b1;
   endtask

   task automatic test_random_messages();
      int sent;
      int len;
      int msgs;
      sent = 0;
      msgs = 0;
      while (sent < RANDOM_UNITS) begin
         len = $urandom_range(1, 12);
         // Run some messages with both sides at full rate.
         send_idle = ($urandom_range(0, 5) != 0);
         recv_idle = ($urandom_range(0, 5) != 0);
         for (int k = 0; k < len; k++)
            send_unit(draw_unit(), k == len - 1);
         sent += len;
         msgs++;
         if (msgs % 8 == 0) wait_drained();
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // Symbol side: random stall before each beat, plus the long hold on request.
   initial begin : symbol_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = recv_idle ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid && rsp_hold_cycles == 0) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      symbol_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_symbols.size() == 0) begin
            failed = 1'b1;
            $display("%0t: unexpected symbol %h run_end=%b message_end=%b", $time,
                     rsp_ch.symbol_char, rsp_ch.run_end, rsp_ch.message_end);
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_ch.symbol_char !== want.symbol || rsp_ch.run_end !== want.run_end ||
                rsp_ch.message_end !== want.message_end) begin
               failed = 1'b1;
               $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b", $time,
                        want.symbol, want.run_end, want.message_end,
                        rsp_ch.symbol_char, rsp_ch.run_end, rsp_ch.message_end);
            end
         end
      end
   end

   initial begin : watchdog
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      failed = 1'b0;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      rsp_hold_cycles = 0;
      left_count = '0;
      left_bits = '0;
      req_ch.valid = 1'b0;
      req_ch.code_unit = '0;
      req_ch.final_unit = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_single_units();
      test_phase_walk();
      test_backpressure();
      test_random_messages();

      wait_drained();
      repeat (8) @(posedge clock);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
